>>> rtl/pstd_pkg.sv
package pstd_pkg;

    localparam int FREQ_WIDTH_DEF = 16;

    localparam int FIELD_W  = 16;
    localparam int STEP_W   = 10;
    localparam int RATIO_W  = 20;
    localparam int CMP_W    = 8;
    localparam int CIDX_W   = 3;
    localparam int OUT_W    = 2 * FIELD_W + CMP_W;

    localparam logic [FIELD_W-1:0] FREQ_MIN_RST   = 16'd230;
    localparam logic [FIELD_W-1:0] FREQ_MAX_RST   = 16'd1400;
    localparam logic [STEP_W-1:0]  BIG_STEP_RST   = 10'd30;
    localparam logic [STEP_W-1:0]  MID_STEP_RST   = 10'd10;
    localparam logic [RATIO_W-1:0] TONE_RATIO_RST = 20'd31250;

    localparam logic [CMP_W-1:0]   CMP_MIN = 8'd1;
    localparam logic [CMP_W-1:0]   CMP_MAX = 8'd255;

    typedef enum logic [CIDX_W-1:0] {
        REG_FREQ_MIN   = 3'd0,
        REG_FREQ_MAX   = 3'd1,
        REG_BIG_STEP   = 3'd2,
        REG_MID_STEP   = 3'd3,
        REG_TONE_RATIO = 3'd4
    } cfg_index_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SLEW  = 5'b00010,
        ST_CLAMP = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

endpackage

>>> rtl/pitch_slew_tone_divider.sv
// Channel   Direction  Handshake             Payload
// s_        in         s_tvalid / s_tready   target_freq
// m_        out        m_tvalid / m_tready   current_freq, applied_freq, compare_value
// cfg_      in         cfg_valid / cfg_ready register index and write data
//
// Each item passes through the states in order: accept (IDLE), one slew step (SLEW), one clamp
// (CLAMP), the restoring divider (DIV, one quotient bit of tone_ratio per cycle), and the
// output load (DONE); the next item is accepted only after DONE returns to IDLE.
// The output register holds a result until it is taken; the next item is accepted meanwhile.
// A stalled output holds the divider result in the final state until the register frees.
// Reset is synchronous and active low; it restores the register defaults and a zero frequency.
module pitch_slew_tone_divider #(
    parameter int FREQ_WIDTH = pstd_pkg::FREQ_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [15:0] target_freq
    input  logic [pstd_pkg::FIELD_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [15:0] current_freq, [31:16] applied_freq, [39:32] compare_value
    output logic [pstd_pkg::OUT_W-1:0]    m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pstd_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [pstd_pkg::RATIO_W-1:0]  cfg_data
);

    localparam int W    = FREQ_WIDTH;
    localparam int FW   = pstd_pkg::FIELD_W;
    localparam int SW   = pstd_pkg::STEP_W;
    localparam int RW   = pstd_pkg::RATIO_W;
    localparam int CMPW = pstd_pkg::CMP_W;
    localparam int DW   = W + SW + 1;
    localparam int CW   = (W > FW) ? W : FW;
    localparam int CNTW = $clog2(RW);

    pstd_pkg::state_t state_reg, state_next;

    logic [FW-1:0]   freq_min_reg, freq_max_reg;
    logic [SW-1:0]   big_step_reg, mid_step_reg;
    logic [RW-1:0]   tone_ratio_reg;

    logic [W-1:0]    target_reg, target_next;
    logic [W-1:0]    slew_reg, slew_next;
    logic [FW-1:0]   applied_reg, applied_next;
    logic [FW-1:0]   rem_reg, rem_next;
    logic [RW-1:0]   quot_reg, quot_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;

    logic                 m_valid_reg, m_valid_next;
    logic [FW-1:0]        out_cur_reg, out_cur_next;
    logic [FW-1:0]        out_app_reg, out_app_next;
    logic [CMPW-1:0]      out_cmp_reg, out_cmp_next;

    logic                 in_fire, out_free;
    logic [W-1:0]         diff;
    logic signed [DW-1:0] d_ext, big_ext, mid_ext;
    logic [DW-1:0]        step_ext;
    logic                 step_up;
    logic [CW-1:0]        clamp_lo, clamp_hi;
    logic [FW:0]          partial;
    logic [FW+1:0]        trial;
    logic [CMPW-1:0]      cmp_val;

    assign s_tready  = (state_reg == pstd_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {out_cmp_reg, out_app_reg, out_cur_reg};

    // Slew decision on the two's-complement difference.
    assign diff    = target_reg - slew_reg;
    assign d_ext   = $signed({{(SW + 1){diff[W-1]}}, diff});
    assign big_ext = $signed({{(DW - SW){1'b0}}, big_step_reg});
    assign mid_ext = $signed({{(DW - SW){1'b0}}, mid_step_reg});

    always_comb begin
        step_up  = 1'b1;
        step_ext = '0;
        if (d_ext > big_ext) begin
            step_ext = DW'(big_step_reg);
        end else if (d_ext > mid_ext) begin
            step_ext = DW'(mid_step_reg);
        end else if (d_ext > $signed(DW'(0))) begin
            step_ext = DW'(1);
        end else if (d_ext < -big_ext) begin
            step_up  = 1'b0;
            step_ext = DW'(big_step_reg);
        end else if (d_ext < -mid_ext) begin
            step_up  = 1'b0;
            step_ext = DW'(mid_step_reg);
        end else if (d_ext < $signed(DW'(0))) begin
            step_up  = 1'b0;
            step_ext = DW'(1);
        end
    end

    // Raise to the minimum first, then lower to the maximum.
    always_comb begin
        clamp_lo = (CW'(slew_reg) < CW'(freq_min_reg)) ? CW'(freq_min_reg) : CW'(slew_reg);
        clamp_hi = (clamp_lo > CW'(freq_max_reg)) ? CW'(freq_max_reg) : clamp_lo;
    end

    // One restoring divider step per cycle.
    assign partial = {rem_reg, quot_reg[RW-1]};
    assign trial   = {1'b0, partial} - {2'b00, applied_reg};

    always_comb begin
        if (quot_reg <= RW'(2)) begin
            cmp_val = pstd_pkg::CMP_MIN;
        end else if (quot_reg > RW'(256)) begin
            cmp_val = pstd_pkg::CMP_MAX;
        end else begin
            cmp_val = CMPW'(quot_reg - RW'(1));
        end
    end

    always_comb begin
        state_next   = state_reg;
        target_next  = target_reg;
        slew_next    = slew_reg;
        applied_next = applied_reg;
        rem_next     = rem_reg;
        quot_next    = quot_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_tready;
        out_cur_next = out_cur_reg;
        out_app_next = out_app_reg;
        out_cmp_next = out_cmp_reg;
        case (state_reg)
            pstd_pkg::ST_IDLE: begin
                if (in_fire) begin
                    target_next = W'(s_tdata);
                    state_next  = pstd_pkg::ST_SLEW;
                end
            end
            pstd_pkg::ST_SLEW: begin
                slew_next  = step_up ? (slew_reg + step_ext[W-1:0])
                                     : (slew_reg - step_ext[W-1:0]);
                state_next = pstd_pkg::ST_CLAMP;
            end
            pstd_pkg::ST_CLAMP: begin
                applied_next = clamp_hi[FW-1:0];
                rem_next     = '0;
                quot_next    = tone_ratio_reg;
                cnt_next     = CNTW'(RW - 1);
                state_next   = pstd_pkg::ST_DIV;
            end
            pstd_pkg::ST_DIV: begin
                rem_next  = trial[FW+1] ? partial[FW-1:0] : trial[FW-1:0];
                quot_next = {quot_reg[RW-2:0], ~trial[FW+1]};
                cnt_next  = cnt_reg - CNTW'(1);
                if (cnt_reg == '0) begin
                    state_next = pstd_pkg::ST_DONE;
                end
            end
            pstd_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    out_cur_next = FW'(slew_reg);
                    out_app_next = applied_reg;
                    out_cmp_next = cmp_val;
                    state_next   = pstd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pstd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= pstd_pkg::ST_IDLE;
            m_valid_reg    <= 1'b0;
            slew_reg       <= '0;
            freq_min_reg   <= pstd_pkg::FREQ_MIN_RST;
            freq_max_reg   <= pstd_pkg::FREQ_MAX_RST;
            big_step_reg   <= pstd_pkg::BIG_STEP_RST;
            mid_step_reg   <= pstd_pkg::MID_STEP_RST;
            tone_ratio_reg <= pstd_pkg::TONE_RATIO_RST;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            slew_reg    <= slew_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    pstd_pkg::REG_FREQ_MIN:   freq_min_reg   <= cfg_data[FW-1:0];
                    pstd_pkg::REG_FREQ_MAX:   freq_max_reg   <= cfg_data[FW-1:0];
                    pstd_pkg::REG_BIG_STEP:   big_step_reg   <= cfg_data[SW-1:0];
                    pstd_pkg::REG_MID_STEP:   mid_step_reg   <= cfg_data[SW-1:0];
                    pstd_pkg::REG_TONE_RATIO: tone_ratio_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        target_reg  <= target_next;
        applied_reg <= applied_next;
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
        cnt_reg     <= cnt_next;
        out_cur_reg <= out_cur_next;
        out_app_reg <= out_app_next;
        out_cmp_reg <= out_cmp_next;
    end

endmodule

>>> rtl/pstd_checker.sv
module pstd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [pstd_pkg::OUT_W-1:0]    m_tdata
);

    localparam int CMP_LSB = 2 * pstd_pkg::FIELD_W;

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output item changed");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted item");

    a_cmp_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[CMP_LSB +: pstd_pkg::CMP_W] != '0)
        else $error("compare value of zero");

endmodule

bind pitch_slew_tone_divider pstd_checker u_pstd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
